### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the policer top level. They compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/stpp_pkg.sv
// ---------------------------------------------------------------------------
// stpp_pkg
// Types, codes and the tier classifier of the stress-tier packet policer.
// ---------------------------------------------------------------------------
package stpp_pkg;

	// Tier codes
	localparam logic [1:0] TIER_VITAL    = 2'd0;
	localparam logic [1:0] TIER_NORMAL   = 2'd1;
	localparam logic [1:0] TIER_DEFER    = 2'd2;
	localparam logic [1:0] TIER_EARLY    = 2'd3;

	// Event slot codes
	localparam logic [2:0] SLOT_VITAL_PASS     = 3'd0;
	localparam logic [2:0] SLOT_NORMAL_PASS    = 3'd1;
	localparam logic [2:0] SLOT_NORMAL_THROTTLE = 3'd2;
	localparam logic [2:0] SLOT_DEFER_PASS     = 3'd3;
	localparam logic [2:0] SLOT_DEFER_THROTTLE = 3'd4;
	localparam logic [2:0] SLOT_DEFER_DROP     = 3'd5;
	localparam logic [2:0] SLOT_NONE           = 3'd6;
	localparam int         SLOT_COUNT          = 6;

	// Stress states
	localparam logic [1:0] MODE_CALM     = 2'd0;
	localparam logic [1:0] MODE_ALERT    = 2'd1;
	localparam logic [1:0] MODE_FIGHT    = 2'd2;
	localparam logic [1:0] MODE_RECOVERY = 2'd3;

	// Configuration register indexes
	localparam int         CFG_INDEX_BITS       = 8;
	localparam int         CFG_DATA_BITS        = 7;
	localparam logic [7:0] CFG_STRESS_STATE     = 8'd0;
	localparam logic [7:0] CFG_NORMAL_FIGHT_PCT = 8'd1;
	localparam logic [7:0] CFG_DEFER_ALERT_PCT  = 8'd2;
	localparam logic [7:0] CFG_DEFER_RECOV_PCT  = 8'd3;

	// Header constants
	localparam logic [15:0] ETHER_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [15:0] ETH_LEN      = 16'd14;
	localparam logic [15:0] ETH_IPV4_LEN = 16'd34;
	localparam logic [6:0]  TCP_LEN      = 7'd20;
	localparam logic [6:0]  UDP_LEN      = 7'd8;

	// Well-known ports
	localparam logic [15:0] SVC_DNS      = 16'd53;
	localparam logic [15:0] SVC_SSH      = 16'd22;
	localparam logic [15:0] SVC_HTTP     = 16'd80;
	localparam logic [15:0] SVC_HTTPS    = 16'd443;
	localparam logic [15:0] SVC_MESH     = 16'd8144;
	localparam logic [15:0] SVC_STUN     = 16'd3478;
	localparam logic [15:0] SVC_CTRL     = 16'd8766;
	localparam logic [15:0] SVC_NTP      = 16'd123;
	localparam logic [15:0] SVC_SMTP     = 16'd25;
	localparam logic [15:0] SVC_SMTP_SUB = 16'd587;
	localparam logic [15:0] SVC_PRIV_END = 16'd1024;

	// Throttle roll: x / 100 = (x * DIV100_MAGIC) >> DIV100_SHIFT for 32-bit x
	localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
	localparam int          DIV100_SHIFT = 37;
	localparam int          ROLL_BITS    = 7;

	// Queue between classifier and counter stage
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0] stress_state;
		logic [6:0] normal_fight_pct;
		logic [6:0] defer_alert_pct;
		logic [6:0] defer_recovery_pct;
	} cfg_t;

	typedef struct packed {
		logic       drop;
		logic [1:0] tier;
		logic [2:0] slot;
	} item_t;

	// Sort a packet into a tier by protocol and ports
	function automatic logic [1:0] tier_of(input logic [15:0] dp, input logic [15:0] sp,
			input logic [7:0] proto);
		logic [1:0] t;
		t = TIER_DEFER;
		if (proto == PROTO_ICMP) begin
			t = TIER_VITAL;
		end else if (dp == SVC_DNS || sp == SVC_DNS || dp == SVC_SSH) begin
			t = TIER_VITAL;
		end else if (dp == SVC_MESH || sp == SVC_MESH || dp == SVC_STUN ||
				sp == SVC_STUN || dp == SVC_CTRL || sp == SVC_CTRL) begin
			t = TIER_VITAL;
		end else if (dp == SVC_NTP || sp == SVC_NTP) begin
			t = TIER_VITAL;
		end else if (dp == SVC_HTTP || dp == SVC_HTTPS || sp == SVC_HTTP ||
				sp == SVC_HTTPS) begin
			t = TIER_NORMAL;
		end else if (dp == SVC_SMTP || dp == SVC_SMTP_SUB) begin
			t = TIER_NORMAL;
		end else if (sp > SVC_PRIV_END && dp < SVC_PRIV_END) begin
			t = TIER_NORMAL;
		end
		return t;
	endfunction

endpackage

### rtl/stpp_front.sv
// ---------------------------------------------------------------------------
// stpp_front
// Accepts header summaries, classifies them and makes the throttle decision
// over two pipeline stages, then pushes the verdict into the queue.
// ---------------------------------------------------------------------------
module stpp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       ether_type,
	input  logic [7:0]        ip_protocol,
	input  logic [3:0]        ip_header_words,
	input  logic [15:0]       frame_bytes,
	input  logic [31:0]       source_address,
	input  logic [15:0]       source_port,
	input  logic [15:0]       dest_port,
	input  logic [63:0]       arrival_time_ns,
	input  stpp_pkg::cfg_t    cfg,
	output logic              push,
	output stpp_pkg::item_t   push_item,
	input  logic              full
);
	import stpp_pkg::*;

	logic                  v_s1, v_s2;
	logic                  early_s1, early_s2;
	logic [1:0]            tier_s1, tier_s2;
	logic [31:0]           mix_s1;
	logic [ROLL_BITS-1:0]  mix_lo_s2;
	logic [ROLL_BITS-1:0]  quot_lo_s2;
	logic                  load_s1, load_s2;
	logic                  is_l4, is_tcp, early;
	logic [6:0]            need;
	logic [15:0]           sp, dp;
	logic [63:0]           mix_wide;
	logic [63:0]           prod;
	logic [12:0]           quot_x100;
	logic [ROLL_BITS-1:0]  roll;

	// Stall the input when the first stage cannot move on
	assign load_s2  = !v_s2 || !full;
	assign load_s1  = !v_s1 || load_s2;
	assign in_stall = !load_s1;
	assign push     = v_s2 && !full;

	// Classify: early pass on short or non-IPv4 frames
	assign is_tcp = (ip_protocol == PROTO_TCP);
	assign is_l4  = is_tcp || (ip_protocol == PROTO_UDP);
	assign need   = 7'(ETH_LEN) + {1'b0, ip_header_words, 2'b00} + (is_tcp ? TCP_LEN : UDP_LEN);
	assign early  = (frame_bytes < ETH_LEN) || (ether_type != ETHER_IPV4) ||
		(frame_bytes < ETH_IPV4_LEN) || (is_l4 && (16'(need) > frame_bytes));
	assign sp = is_l4 ? source_port : 16'd0;
	assign dp = is_l4 ? dest_port : 16'd0;
	assign mix_wide = arrival_time_ns ^ 64'(source_address) ^ (arrival_time_ns >> 17);

	// Stage 1: register classification and throttle entropy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			early_s1 <= early;
			tier_s1  <= tier_of(dp, sp, ip_protocol);
			mix_s1   <= mix_wide[31:0];
		end
	end

	// Stage 2: quotient by 100 through reciprocal multiply, keep low bits only
	assign prod = 64'(mix_s1) * 64'(DIV100_MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			early_s2   <= early_s1;
			tier_s2    <= tier_s1;
			mix_lo_s2  <= mix_s1[ROLL_BITS-1:0];
			quot_lo_s2 <= prod[DIV100_SHIFT +: ROLL_BITS];
		end
	end

	// Remainder below 100 fits in seven bits, so modular arithmetic suffices
	assign quot_x100 = {quot_lo_s2, 6'b0} + {1'b0, quot_lo_s2, 5'b0} + {4'b0, quot_lo_s2, 2'b0};
	assign roll      = mix_lo_s2 - quot_x100[ROLL_BITS-1:0];

	// Apply the stress decision matrix
	always_comb begin
		push_item.drop = 1'b0;
		push_item.tier = tier_s2;
		push_item.slot = SLOT_NONE;
		if (early_s2) begin
			push_item.tier = TIER_EARLY;
		end else begin
			case (tier_s2)
				TIER_VITAL: begin
					push_item.slot = SLOT_VITAL_PASS;
				end
				TIER_NORMAL: begin
					if (cfg.stress_state == MODE_FIGHT && roll >= cfg.normal_fight_pct) begin
						push_item.slot = SLOT_NORMAL_THROTTLE;
						push_item.drop = 1'b1;
					end else begin
						push_item.slot = SLOT_NORMAL_PASS;
					end
				end
				default: begin
					if (cfg.stress_state == MODE_FIGHT) begin
						push_item.slot = SLOT_DEFER_DROP;
						push_item.drop = 1'b1;
					end else if (cfg.stress_state == MODE_ALERT &&
							roll >= cfg.defer_alert_pct) begin
						push_item.slot = SLOT_DEFER_THROTTLE;
						push_item.drop = 1'b1;
					end else if (cfg.stress_state == MODE_RECOVERY &&
							roll >= cfg.defer_recovery_pct) begin
						push_item.slot = SLOT_DEFER_THROTTLE;
						push_item.drop = 1'b1;
					end else begin
						push_item.slot = SLOT_DEFER_PASS;
					end
				end
			endcase
		end
	end

endmodule

### rtl/stpp_queue.sv
// ---------------------------------------------------------------------------
// stpp_queue
// Short FIFO of verdicts between the classifier and the counter stage.
// ---------------------------------------------------------------------------
module stpp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stpp_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output stpp_pkg::item_t pop_item,
	output logic            empty
);
	import stpp_pkg::*;

	item_t                     entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign full     = (count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	// Store the incoming verdict
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/stpp_back.sv
// ---------------------------------------------------------------------------
// stpp_back
// Pops verdicts, bumps the matching event counter and holds the result
// transaction in an output register.
// ---------------------------------------------------------------------------
module stpp_back #(
	parameter int COUNTER_BITS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	output logic            pop,
	input  stpp_pkg::item_t head,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            drop,
	output logic [1:0]      tier,
	output logic [2:0]      stat_slot,
	output logic [63:0]     stat_count
);
	import stpp_pkg::*;

	logic [COUNTER_BITS-1:0] cnt_q [SLOT_COUNT];
	logic [COUNTER_BITS-1:0] cnt_next;
	logic                    counted;
	logic                    out_valid_q;
	logic                    drop_q;
	logic [1:0]              tier_q;
	logic [2:0]              slot_q;
	logic [63:0]             count_q;

	// Take the next verdict when the output register is free or draining
	assign pop     = !empty && (!out_valid_q || !out_stall);
	assign counted = (head.slot != SLOT_NONE);
	assign cnt_next = counted ? cnt_q[head.slot] + 1'b1 : '0;

	// Bump the event counter of this verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (pop && counted) begin
			cnt_q[head.slot] <= cnt_next;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			drop_q  <= head.drop;
			tier_q  <= head.tier;
			slot_q  <= head.slot;
			count_q <= 64'(cnt_next);
		end
	end

	assign out_valid  = out_valid_q;
	assign drop       = drop_q;
	assign tier       = tier_q;
	assign stat_slot  = slot_q;
	assign stat_count = count_q;

endmodule

### rtl/stress_tier_packet_policer_top.sv
// ---------------------------------------------------------------------------
// stress_tier_packet_policer_top
// Classifies packet header summaries into tiers, polices them by stress state
// and keeps six wrapping event counters.
// ---------------------------------------------------------------------------
//   channel   handshake              payload
//   input     in_valid / in_stall    ether_type .. arrival_time_ns
//   result    out_valid / out_stall  drop, tier, stat_slot, stat_count
//   config    cfg_wr_en              cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a result is registered
// through stage one (loaded on the accepting edge), stage two, the queue and the
// output register, in that order.
// The reciprocal multiply in the second classifier stage sets the clock path.
// Reset clears counters, pipeline valids, the queue and loads register defaults.
// A stalled output fills the queue, then the classifier, then stalls the input.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stress_tier_packet_policer_top #(
	parameter int COUNTER_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [15:0]                         ether_type,
	input  logic [7:0]                          ip_protocol,
	input  logic [3:0]                          ip_header_words,
	input  logic [15:0]                         frame_bytes,
	input  logic [31:0]                         source_address,
	input  logic [15:0]                         source_port,
	input  logic [15:0]                         dest_port,
	input  logic [63:0]                         arrival_time_ns,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                drop,
	output logic [1:0]                          tier,
	output logic [2:0]                          stat_slot,
	output logic [63:0]                         stat_count,
	input  logic                                cfg_wr_en,
	input  logic [stpp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [stpp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import stpp_pkg::*;

	cfg_t  cfg_q;
	logic  push, full, pop, empty;
	item_t push_item, head;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stress_state       <= MODE_CALM;
			cfg_q.normal_fight_pct   <= 7'd75;
			cfg_q.defer_alert_pct    <= 7'd50;
			cfg_q.defer_recovery_pct <= 7'd75;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_STRESS_STATE:     cfg_q.stress_state       <= cfg_data[1:0];
				CFG_NORMAL_FIGHT_PCT: cfg_q.normal_fight_pct   <= cfg_data;
				CFG_DEFER_ALERT_PCT:  cfg_q.defer_alert_pct    <= cfg_data;
				CFG_DEFER_RECOV_PCT:  cfg_q.defer_recovery_pct <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	stpp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.ether_type      (ether_type),
		.ip_protocol     (ip_protocol),
		.ip_header_words (ip_header_words),
		.frame_bytes     (frame_bytes),
		.source_address  (source_address),
		.source_port     (source_port),
		.dest_port       (dest_port),
		.arrival_time_ns (arrival_time_ns),
		.cfg             (cfg_q),
		.push            (push),
		.push_item       (push_item),
		.full            (full)
	);

	stpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (head),
		.empty     (empty)
	);

	stpp_back #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.pop        (pop),
		.head       (head),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.drop       (drop),
		.tier       (tier),
		.stat_slot  (stat_slot),
		.stat_count (stat_count)
	);

	// Early pass and the uncounted slot always travel together
	`ASSERT_HOLDS(a_early_slot, clk, arst_n,
		!out_valid || ((tier == TIER_EARLY) == (stat_slot == SLOT_NONE)),
		"early pass and uncounted slot disagree")
	// A drop comes only from a throttle or drop slot
	`ASSERT_IMPLIES(a_drop_slot, clk, arst_n, out_valid && drop,
		stat_slot == SLOT_NORMAL_THROTTLE || stat_slot == SLOT_DEFER_THROTTLE ||
		stat_slot == SLOT_DEFER_DROP, "drop without a drop slot")
	// Vital traffic always passes into its own slot
	`ASSERT_IMPLIES(a_vital_pass, clk, arst_n, out_valid && tier == TIER_VITAL,
		!drop && stat_slot == SLOT_VITAL_PASS, "vital packet not passed")

endmodule
